[hw/rtl/i2c_master_transfer_sequencer_top_assert.svh]
// assertion macros for the i2c master transfer sequencer
// used by the top level; needs no package
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_TOP_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_TOP_ASSERT_SVH

// implication checked on every clock edge outside reset
`define I2CMS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the next cycle, outside reset
`define I2CMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/i2cms_pkg.sv]
// shared types and constants of the i2c master transfer sequencer
// used by the buffer ram, the control unit and the top level
package i2cms_pkg;

  localparam int unsigned MAX_BYTES = 64;
  localparam int unsigned BUF_AW    = $clog2(MAX_BYTES);
  localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BYTES);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_EVENT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_TX    = 2'd2,
    PH_RX    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_START     = 3'd1,
    ACT_SEND      = 3'd2,
    ACT_RECV_NACK = 3'd3,
    ACT_STOP      = 3'd4
  } action_t;

  localparam logic [7:0] STATUS_MASK   = 8'hF8;
  localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
  localparam logic [7:0] ST_DATA_ACK   = 8'h28;
  localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_NACK  = 8'h30;
  localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
  localparam logic [7:0] ST_RX_NACK    = 8'h58;
  localparam logic [7:0] RW_READ       = 8'h01;

  // one result as produced by the control unit at acceptance
  typedef struct packed {
    logic       accepted;
    action_t    action;
    logic       use_ram;
    logic [7:0] byte_out;
    logic [7:0] read_data;
    logic       done;
    logic       busy;
  } ctrl_res_t;

  typedef struct packed {
    logic              rd_en;
    logic [BUF_AW-1:0] rd_addr;
  } ram_rd_t;

endpackage

[hw/rtl/i2cms_buf_ram.sv]
// send buffer: one write port, one registered read port
// depends on i2cms_pkg
module i2cms_buf_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [i2cms_pkg::BUF_AW-1:0] wr_addr,
  input  logic [7:0]                 wr_data,
  input  i2cms_pkg::ram_rd_t         rd,
  output logic [7:0]                 rd_data
);
  import i2cms_pkg::*;

  logic [7:0] mem [MAX_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.rd_en) begin
      rd_data_r <= mem[rd.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/i2cms_ctrl.sv]
// transfer control: phase machine, counters, address and read byte
// depends on i2cms_pkg
module i2cms_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  i2cms_pkg::cmd_t            cmd,
  input  logic [6:0]                 target_address,
  input  logic [6:0]                 transfer_length,
  input  logic [7:0]                 bus_status,
  input  logic [7:0]                 received_byte,
  output i2cms_pkg::ctrl_res_t       res,
  output i2cms_pkg::ram_rd_t         rd
);
  import i2cms_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] bytes_r, bytes_nxt;
  logic [CNT_W-1:0] slot_r, slot_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic             done_r, done_nxt;
  logic [7:0]       last_r, last_nxt;

  logic [7:0]       status;
  logic             tx_more;
  logic             is_start;
  logic [CNT_W-1:0] len_sat;

  always_comb begin
    status   = bus_status & STATUS_MASK;
    tx_more  = (slot_r < bytes_r) && (slot_r < MAX_CNT);
    is_start = (cmd == CMD_WRITE) || (cmd == CMD_READ);
    len_sat  = ({1'b0, transfer_length} > {1'b0, 7'(MAX_BYTES)}) ? MAX_CNT
             : CNT_W'(transfer_length);
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    bytes_nxt = bytes_r;
    slot_nxt  = slot_r;
    addr_nxt  = addr_r;
    done_nxt  = done_r;
    last_nxt  = last_r;
    if (is_start && phase_r == PH_IDLE) begin
      if (cmd == CMD_WRITE) begin
        bytes_nxt = len_sat;
        slot_nxt  = '0;
        addr_nxt  = {target_address, 1'b0};
      end else begin
        addr_nxt  = {target_address, 1'b0} | RW_READ;
      end
      done_nxt  = 1'b0;
      phase_nxt = PH_START;
    end else if (cmd == CMD_EVENT) begin
      unique case (phase_r)
        PH_START: begin
          phase_nxt = ((addr_r & RW_READ) != 8'h00) ? PH_RX : PH_TX;
        end
        PH_TX: begin
          if (status == ST_SLAW_ACK || status == ST_DATA_ACK) begin
            if (tx_more) begin
              slot_nxt = slot_r + CNT_W'(1);
            end else begin
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end
          end else if (status == ST_SLAW_NACK || status == ST_DATA_NACK) begin
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end
        end
        PH_RX: begin
          if (status != ST_SLAR_ACK) begin
            if (status == ST_RX_NACK) begin
              last_nxt = received_byte;
            end
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end
        end
        PH_IDLE: begin
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    res.accepted = 1'b0;
    res.action   = ACT_NONE;
    res.use_ram  = 1'b0;
    res.byte_out = 8'h00;
    rd.rd_en     = 1'b0;
    rd.rd_addr   = slot_r[BUF_AW-1:0];
    if (is_start && phase_r == PH_IDLE) begin
      res.accepted = 1'b1;
      res.action   = ACT_START;
    end else if (cmd == CMD_EVENT) begin
      unique case (phase_r)
        PH_START: begin
          res.action   = ACT_SEND;
          res.byte_out = addr_r;
        end
        PH_TX: begin
          if (status == ST_SLAW_ACK || status == ST_DATA_ACK) begin
            if (tx_more) begin
              res.action  = ACT_SEND;
              res.use_ram = 1'b1;
              rd.rd_en    = fire;
            end else begin
              res.action = ACT_STOP;
            end
          end else if (status == ST_SLAW_NACK || status == ST_DATA_NACK) begin
            res.action = ACT_STOP;
          end
        end
        PH_RX: begin
          res.action = (status == ST_SLAR_ACK) ? ACT_RECV_NACK : ACT_STOP;
        end
        PH_IDLE: begin
        end
      endcase
    end
    res.read_data = last_nxt;
    res.done      = done_nxt;
    res.busy      = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bytes_r <= '0;
      slot_r  <= '0;
      addr_r  <= 8'h00;
      done_r  <= 1'b0;
      last_r  <= 8'h00;
    end else if (fire) begin
      phase_r <= phase_nxt;
      bytes_r <= bytes_nxt;
      slot_r  <= slot_nxt;
      addr_r  <= addr_nxt;
      done_r  <= done_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

[hw/rtl/i2c_master_transfer_sequencer_top.sv]
// a result beat appears the cycle after its input beat is taken
// throughput: one input beat per cycle while the output is not stalled; the send buffer is read once at acceptance
//   and its registered data joins the result in the output stage
// reset: synchronous, active low; clears phase, counters, flags and the output valid
//   bit; the send buffer is not cleared and holds garbage until loaded
// depends on i2cms_pkg, i2cms_buf_ram, i2cms_ctrl and the assertion macro header
module i2c_master_transfer_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // lowest bit up: byte_index[5:0], byte_value[13:6], target_address[20:14],
  // transfer_length[27:21], bus_status[35:28], received_byte[43:36], zero[47:44]
  input  logic [47:0] in_tdata,
  // command[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // lowest bit up: accepted[0], bus_action[3:1], bus_byte[11:4],
  // read_data[19:12], transfer_done[20], busy_res[21], zero[23:22]
  output logic [23:0] out_tdata
);
  import i2cms_pkg::*;

`include "i2c_master_transfer_sequencer_top_assert.svh"

  // input field split
  logic [5:0] byte_index;
  logic [7:0] byte_value;
  logic [6:0] target_address;
  logic [6:0] transfer_length;
  logic [7:0] bus_status;
  logic [7:0] received_byte;
  cmd_t       command;

  assign byte_index      = in_tdata[5:0];
  assign byte_value      = in_tdata[13:6];
  assign target_address  = in_tdata[20:14];
  assign transfer_length = in_tdata[27:21];
  assign bus_status      = in_tdata[35:28];
  assign received_byte   = in_tdata[43:36];
  assign command         = cmd_t'(in_tuser);

  // output stage: one result register, refilled in the cycle it drains
  logic      out_valid_r;
  ctrl_res_t out_res_r;
  logic      in_fire;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  ctrl_res_t  res;
  ram_rd_t    rd;
  logic [7:0] ram_q;
  logic       ram_we;

  // loads go straight to the buffer; slots past the end are dropped
  assign ram_we = in_fire && (command == CMD_LOAD)
               && ({1'b0, byte_index} < MAX_CNT);

  i2cms_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (in_fire),
    .cmd             (command),
    .target_address  (target_address),
    .transfer_length (transfer_length),
    .bus_status      (bus_status),
    .received_byte   (received_byte),
    .res             (res),
    .rd              (rd)
  );

  // the read is issued at acceptance, so an earlier load is already written
  // and a later one lands after the read; no forwarding needed
  i2cms_buf_ram u_buf (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (byte_index[BUF_AW-1:0]),
    .wr_data (byte_value),
    .rd      (rd),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res_r <= res;
    end
  end

  // ram_q only moves on acceptance, so it stays with the held result
  logic [7:0] bus_byte;
  assign bus_byte   = out_res_r.use_ram ? ram_q : out_res_r.byte_out;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.busy, out_res_r.done, out_res_r.read_data,
                       bus_byte, out_res_r.action, out_res_r.accepted};

  // a stop always ends the transfer and raises done
  `I2CMS_ASSERT_IMP(a_stop_ends, clk, rst_n,
    out_valid_r && out_res_r.action == ACT_STOP,
    out_res_r.done && !out_res_r.busy, "stop without done or with busy")
  // a taken start leaves the block busy with done cleared
  `I2CMS_ASSERT_IMP(a_start_busy, clk, rst_n,
    out_valid_r && out_res_r.accepted,
    out_res_r.busy && !out_res_r.done && out_res_r.action == ACT_START,
    "accepted start without busy")
  // a buffer read is only ever taken for a send action
  `I2CMS_ASSERT_NEXT(a_ram_send, clk, rst_n,
    rd.rd_en,
    out_valid_r && out_res_r.use_ram && out_res_r.action == ACT_SEND,
    "buffer read not tied to a send")

endmodule
